>>> hw/rtl/spicr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spicr_pkg
// Shared types and constants for the SPI controller register block.
// ----------------------------------------------------------------------------
package spicr_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PIN   = 2'd2;
    localparam logic [1:0] OP_DMA   = 2'd3;

    localparam logic [2:0] K_READ    = 3'd0;
    localparam logic [2:0] K_XCHG    = 3'd1;
    localparam logic [2:0] K_RXDMA   = 3'd2;
    localparam logic [2:0] K_TXREQ   = 3'd3;
    localparam logic [2:0] K_SELECT  = 3'd4;
    localparam logic [2:0] K_RELEASE = 3'd5;

    localparam logic [1:0] REG_CR1  = 2'd0;
    localparam logic [1:0] REG_CR2  = 2'd1;
    localparam logic [1:0] REG_SR   = 2'd2;
    localparam logic [1:0] REG_DATA = 2'd3;

    localparam int CR1_EN_BIT = 6;
    localparam int CR2_RXDMA_BIT = 0;
    localparam int CR2_TXDMA_BIT = 1;

    localparam logic [6:0] PIN_DEV4 = 7'd45;
    localparam logic [6:0] PIN_DEV2 = 7'd46;
    localparam logic [6:0] PIN_DEV3 = 7'd47;
    localparam logic [6:0] PIN_DEV1 = 7'd68;

    localparam logic [1:0] CFG_DEV1 = 2'd0;
    localparam logic [1:0] CFG_DEV2 = 2'd1;
    localparam logic [1:0] CFG_DEV4 = 2'd2;

    localparam logic signed [4:0] CS_NONE = -5'sd1;
    localparam logic signed [3:0] LG_NONE = -4'sd1;

    // controller -> datapath commands
    typedef struct packed {
        logic       load;      // capture the item
        logic       do_emit;   // put result on output
        logic [2:0] emit_kind;
        logic       emit_last;
        logic       rd_pop;    // data read pops FIFO
        logic       wr_ctrl;   // apply CR1/CR2 write
        logic       push;      // push rx byte into FIFO
        logic       set_sel;   // commit new select
        logic       set_pin;   // pin_driven_select <= 1
        logic       release_sel;
        logic       next_byte; // advance exchange index
    } spicr_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic       op_read;
        logic       op_write;
        logic       op_pin;
        logic       op_dma;
        logic [1:0] reg_sel;
        logic       cr1_en_new;   // CR1 enable after pending write
        logic       cr1_en;
        logic       tx_dma_en;    // with pending write applied
        logic       rx_dma_go;
        logic       pin_drv;
        logic       phys_valid;
        logic       byte_done;    // current byte is the last
        logic       fifo_full;
        logic       pin_known;
        logic       pin_level;
        logic       ph_valid;     // mapped physical line exists
        logic       already_sel;
        logic       sel_ok;
        logic       release_match;
    } spicr_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/spi_controller_regs_rx_fifo_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spi_controller_regs_rx_fifo_top
// SPI controller register block with receive FIFO.
// Items are taken only while idle (busy low); a new item is not accepted until the last one ends.
// Reads, control writes and pin releases end at decode; pin asserts add a TX check step;
// enabled data writes and DMA items run an exchange then a routing step for each byte.
// Async active-low reset clears registers, selects and FIFO pointers.
// Results are strobed by done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module spi_controller_regs_rx_fifo_top #(
    parameter int RX_DEPTH = 64
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cfg_we,
    input  wire [1:0]         cfg_index,
    input  wire [4:0]         cfg_wdata,
    input  wire               start,
    output logic              busy,
    input  wire [1:0]         opcode,
    input  wire [3:0]         reg_offset,
    input  wire [2:0]         access_size,
    input  wire [31:0]        write_data,
    input  wire [6:0]         pin_id,
    input  wire               pin_level,
    input  wire [7:0]         dma_tx_byte,
    input  wire               dma_burst_last,
    input  wire [31:0]        slave_rx,
    input  wire               select_ok,
    input  wire               dma_rx_ready,
    output logic              done,
    output logic [2:0]        kind,
    output logic [31:0]       data,
    output logic signed [4:0] cs_line,
    output logic              last
);
    import spicr_pkg::*;

    spicr_cmd_t cmd;
    spicr_stat_t stat;
    logic unused_burst;
    assign unused_burst = dma_burst_last;

    spicr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .stat(stat), .cmd(cmd)
    );

    spicr_datapath #(.RX_DEPTH(RX_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .opcode(opcode), .reg_offset(reg_offset), .access_size(access_size),
        .write_data(write_data), .pin_id(pin_id), .pin_level(pin_level),
        .dma_tx_byte(dma_tx_byte), .slave_rx(slave_rx), .select_ok(select_ok),
        .dma_rx_ready(dma_rx_ready), .cmd(cmd), .stat(stat),
        .done(done), .kind(kind), .data(data), .cs_line(cs_line), .last(last)
    );
endmodule
`default_nettype wire

>>> hw/rtl/spicr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spicr_datapath
// Registers, select state, RX FIFO and result register.
// ----------------------------------------------------------------------------
module spicr_datapath #(
    parameter int RX_DEPTH = 64
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_we,
    input  wire [1:0]              cfg_index,
    input  wire [4:0]              cfg_wdata,
    input  wire [1:0]              opcode,
    input  wire [3:0]              reg_offset,
    input  wire [2:0]              access_size,
    input  wire [31:0]             write_data,
    input  wire [6:0]              pin_id,
    input  wire                    pin_level,
    input  wire [7:0]              dma_tx_byte,
    input  wire [31:0]             slave_rx,
    input  wire                    select_ok,
    input  wire                    dma_rx_ready,
    input  wire spicr_pkg::spicr_cmd_t cmd,
    output spicr_pkg::spicr_stat_t stat,
    output logic                   done,
    output logic [2:0]             kind,
    output logic [31:0]            data,
    output logic signed [4:0]      cs_line,
    output logic                   last
);
    import spicr_pkg::*;

    localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int FW = $clog2(RX_DEPTH + 1);
    localparam logic [AW-1:0] PTR_MAX = AW'(RX_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(RX_DEPTH);

    logic signed [4:0] cfg_reg [3];
    logic [31:0] cr1_reg, cr2_reg;
    logic signed [3:0] lsel_reg;
    logic signed [4:0] psel_reg;
    logic pin_reg;
    logic [AW-1:0] wp_reg, rp_reg;
    logic [FW-1:0] fill_reg;
    logic [7:0] mem [RX_DEPTH];
    logic [7:0] rdb_reg;

    // latched item
    logic [1:0] op_reg;
    logic [3:0] off_reg;
    logic [2:0] size_reg;
    logic [31:0] wd_reg, srx_reg;
    logic [6:0] pid_reg;
    logic plev_reg, sok_reg, rdy_reg;
    logic [7:0] dtx_reg;
    logic [1:0] idx_reg, nbytes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= CS_NONE;
            cfg_reg[1] <= CS_NONE;
            cfg_reg[2] <= CS_NONE;
        end
        else if (cfg_we && cfg_index != 2'd3)
        begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            off_reg <= reg_offset;
            size_reg <= access_size;
            wd_reg <= write_data;
            srx_reg <= slave_rx;
            pid_reg <= pin_id;
            plev_reg <= pin_level;
            sok_reg <= select_ok;
            rdy_reg <= dma_rx_ready;
            dtx_reg <= dma_tx_byte;
        end
    end

    // lane helpers
    logic [1:0] sub;
    logic [4:0] sh;
    logic [31:0] mask, wr_merged;
    assign sub = off_reg[1:0];
    assign sh = {sub, 3'b000};
    always_comb
    begin
        case (size_reg)
            3'd1: mask = 32'h0000_00FF;
            3'd2: mask = 32'h0000_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end
    logic full_word;
    assign full_word = size_reg >= 3'd4;

    function automatic logic [31:0] lget(input logic [31:0] r, input logic [4:0] s,
                                         input logic [31:0] m, input logic f);
        lget = f ? r : ((r >> s) & m);
    endfunction

    logic [31:0] old_reg;
    assign old_reg = off_reg[2] ? cr2_reg : cr1_reg;
    assign wr_merged = full_word ? wd_reg
                     : ((old_reg & ~(mask << sh)) | ((wd_reg & mask) << sh));

    // pin mapping
    logic signed [3:0] lg;
    logic signed [4:0] ph;
    always_comb
    begin
        case (pid_reg)
            PIN_DEV4: lg = 4'sd4;
            PIN_DEV2: lg = 4'sd2;
            PIN_DEV3: lg = 4'sd3;
            PIN_DEV1: lg = 4'sd1;
            default:  lg = LG_NONE;
        endcase
        case (lg)
            4'sd1:   ph = cfg_reg[CFG_DEV1];
            4'sd2:   ph = cfg_reg[CFG_DEV2];
            4'sd4:   ph = cfg_reg[CFG_DEV4];
            default: ph = CS_NONE;
        endcase
    end

    logic [1:0] rsel;
    assign rsel = off_reg[3:2];
    logic wr_cr1, wr_cr2;
    assign wr_cr1 = op_reg == OP_WRITE && rsel == REG_CR1;
    assign wr_cr2 = op_reg == OP_WRITE && rsel == REG_CR2;
    logic [31:0] cr1_eff, cr2_eff;
    assign cr1_eff = wr_cr1 ? wr_merged : cr1_reg;
    assign cr2_eff = wr_cr2 ? wr_merged : cr2_reg;

    always_comb
    begin
        case (size_reg)
            3'd0, 3'd1: nbytes = 2'd0;
            3'd2:       nbytes = 2'd1;
            3'd3:       nbytes = 2'd2;
            default:    nbytes = 2'd3;
        endcase
    end

    assign stat.op_read = op_reg == OP_READ;
    assign stat.op_write = op_reg == OP_WRITE;
    assign stat.op_pin = op_reg == OP_PIN;
    assign stat.op_dma = op_reg == OP_DMA;
    assign stat.reg_sel = rsel;
    assign stat.cr1_en_new = cr1_eff[CR1_EN_BIT];
    assign stat.cr1_en = cr1_reg[CR1_EN_BIT];
    assign stat.tx_dma_en = cr1_eff[CR1_EN_BIT] && cr2_eff[CR2_TXDMA_BIT];
    assign stat.rx_dma_go = cr2_reg[CR2_RXDMA_BIT] && rdy_reg;
    assign stat.pin_drv = pin_reg;
    assign stat.phys_valid = !psel_reg[4];
    assign stat.byte_done = (op_reg == OP_DMA) || idx_reg == nbytes;
    assign stat.fifo_full = fill_reg == FILL_MAX;
    assign stat.pin_known = !lg[3];
    assign stat.pin_level = plev_reg;
    assign stat.ph_valid = !ph[4];
    assign stat.already_sel = lsel_reg == lg && psel_reg == ph;
    assign stat.sel_ok = sok_reg;
    assign stat.release_match = lsel_reg == lg && pin_reg;

    // current byte
    logic [7:0] txb, ans, rxb;
    assign txb = (op_reg == OP_DMA) ? dtx_reg : wd_reg[{idx_reg, 3'b000} +: 8];
    assign ans = (op_reg == OP_DMA) ? srx_reg[7:0] : srx_reg[{idx_reg, 3'b000} +: 8];
    assign rxb = psel_reg[4] ? 8'hFF : ans;

    // read value
    logic [31:0] rd_val, sr;
    assign sr = {24'd0, !lsel_reg[3], 5'd0, 1'b1, fill_reg != '0};
    always_comb
    begin
        case (rsel)
            REG_CR1: rd_val = lget(cr1_reg, sh, mask, full_word);
            REG_CR2: rd_val = lget(cr2_reg, sh, mask, full_word);
            REG_SR:  rd_val = lget(sr, sh, mask, full_word);
            default: rd_val = lget({24'd0, rdb_reg}, sh, mask, full_word);
        endcase
    end

    // FIFO storage; head byte prefetched into rdb_reg at item load, 0xFF when empty
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[wp_reg] <= rxb;
        if (cmd.load)
            rdb_reg <= (fill_reg == '0) ? 8'hFF : mem[rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr1_reg <= '0;
            cr2_reg <= '0;
            lsel_reg <= LG_NONE;
            psel_reg <= CS_NONE;
            pin_reg <= 1'b0;
            wp_reg <= '0;
            rp_reg <= '0;
            fill_reg <= '0;
            idx_reg <= '0;
            done <= 1'b0;
            kind <= K_READ;
            data <= '0;
            cs_line <= CS_NONE;
            last <= 1'b0;
        end
        else
        begin
            done <= cmd.do_emit;
            if (cmd.do_emit)
            begin
                kind <= cmd.emit_kind;
                last <= cmd.emit_last;
                case (cmd.emit_kind)
                    K_READ:   begin data <= rd_val; cs_line <= CS_NONE; end
                    K_XCHG:   begin data <= {24'd0, txb}; cs_line <= psel_reg; end
                    K_RXDMA:  begin data <= {24'd0, rxb}; cs_line <= psel_reg; end
                    K_SELECT: begin data <= '0; cs_line <= ph; end
                    default:  begin data <= '0; cs_line <= psel_reg; end
                endcase
            end
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.next_byte)
                idx_reg <= idx_reg + 2'd1;
            if (cmd.wr_ctrl)
            begin
                cr1_reg <= cr1_eff;
                cr2_reg <= cr2_eff;
            end
            if (cmd.rd_pop && fill_reg != '0)
            begin
                rp_reg <= (rp_reg == PTR_MAX) ? '0 : rp_reg + 1'b1;
                fill_reg <= fill_reg - 1'b1;
            end
            if (cmd.push && fill_reg != FILL_MAX)
            begin
                wp_reg <= (wp_reg == PTR_MAX) ? '0 : wp_reg + 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.set_sel)
            begin
                lsel_reg <= lg;
                psel_reg <= ph;
            end
            if (cmd.set_pin)
                pin_reg <= 1'b1;
            if (cmd.release_sel)
            begin
                lsel_reg <= LG_NONE;
                psel_reg <= CS_NONE;
                pin_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/spicr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spicr_ctrl
// Sequencer: decodes the item and issues its results; a new item is taken only when idle.
// ----------------------------------------------------------------------------
module spicr_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    output logic                   busy,
    input  wire spicr_pkg::spicr_stat_t stat,
    output spicr_pkg::spicr_cmd_t  cmd
);
    import spicr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_XCHG, S_ROUTE, S_TXCHK
    } state_t;

    state_t state_reg, state_next;

    assign busy = state_reg != S_IDLE;

    logic fifo_push_ok;
    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        fifo_push_ok = !stat.fifo_full;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (stat.op_read)
                begin
                    cmd.do_emit = 1'b1;
                    cmd.emit_kind = K_READ;
                    cmd.emit_last = 1'b1;
                    cmd.rd_pop = stat.reg_sel == REG_DATA;
                end
                else if (stat.op_write)
                begin
                    case (stat.reg_sel)
                        REG_CR1:
                        begin
                            cmd.wr_ctrl = 1'b1;
                            if (!stat.cr1_en_new && !stat.pin_drv)
                            begin
                                cmd.release_sel = 1'b1;
                                cmd.do_emit = stat.phys_valid;
                                cmd.emit_kind = K_RELEASE;
                                cmd.emit_last = 1'b1;
                            end
                            else
                            begin
                                cmd.do_emit = stat.tx_dma_en && stat.phys_valid;
                                cmd.emit_kind = K_TXREQ;
                                cmd.emit_last = 1'b1;
                            end
                        end
                        REG_CR2:
                        begin
                            cmd.wr_ctrl = 1'b1;
                            cmd.do_emit = stat.tx_dma_en && stat.phys_valid;
                            cmd.emit_kind = K_TXREQ;
                            cmd.emit_last = 1'b1;
                        end
                        REG_DATA:
                        begin
                            if (stat.cr1_en)
                                state_next = S_XCHG;
                        end
                        default: ;
                    endcase
                end
                else if (stat.op_pin)
                begin
                    if (stat.pin_known)
                    begin
                        if (!stat.pin_level)
                        begin
                            if (stat.ph_valid)
                            begin
                                if (stat.already_sel)
                                    cmd.set_pin = 1'b1;
                                else if (stat.sel_ok)
                                begin
                                    cmd.set_pin = 1'b1;
                                    cmd.set_sel = 1'b1;
                                    cmd.do_emit = 1'b1;
                                    cmd.emit_kind = K_SELECT;
                                    // new line is valid, so a TX request follows if enabled
                                    cmd.emit_last = !stat.tx_dma_en;
                                end
                            end
                            state_next = S_TXCHK;
                        end
                        else if (stat.release_match)
                        begin
                            cmd.release_sel = 1'b1;
                            cmd.do_emit = stat.phys_valid;
                            cmd.emit_kind = K_RELEASE;
                            cmd.emit_last = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (stat.cr1_en)
                        state_next = S_XCHG;
                end
            end
            S_TXCHK:
            begin
                // select already committed
                cmd.do_emit = stat.tx_dma_en && stat.phys_valid;
                cmd.emit_kind = K_TXREQ;
                cmd.emit_last = 1'b1;
                state_next = S_IDLE;
            end
            S_XCHG:
            begin
                cmd.do_emit = stat.phys_valid;
                cmd.emit_kind = K_XCHG;
                // last byte going into the FIFO ends the item here
                cmd.emit_last = stat.byte_done && !stat.rx_dma_go;
                state_next = S_ROUTE;
            end
            S_ROUTE:
            begin
                if (stat.rx_dma_go)
                begin
                    cmd.do_emit = 1'b1;
                    cmd.emit_kind = K_RXDMA;
                end
                else
                    cmd.push = fifo_push_ok;
                cmd.emit_last = stat.byte_done;
                if (stat.byte_done)
                    state_next = S_IDLE;
                else
                begin
                    cmd.next_byte = 1'b1;
                    state_next = S_XCHG;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives register, pin and TX DMA items into the SPI controller block and
// checks every strobed result against a behavioral predictor of the register
// file, select logic and receive FIFO, over several select-line mappings.
// ----------------------------------------------------------------------------
module testbench;
    import spicr_pkg::*;

    localparam int DEPTH     = 64;
    localparam int SETTLE    = 14;
    localparam int WDOG_MAX  = 4000;
    localparam int SHOW_MAX  = 10;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  off;
        logic [2:0]  size;
        logic [31:0] wdata;
        logic [6:0]  pin;
        logic        lvl;
        logic [7:0]  txb;
        logic        blast;
        logic [31:0] answers;
        logic        selok;
        logic        rdy;
    } spi_item_t;

    typedef struct {
        logic [2:0]        kind;
        logic [31:0]       data;
        logic signed [4:0] cs;
        logic              last;
    } spi_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [4:0] cfg_wdata = '0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] opcode = '0;
    logic [3:0] reg_offset = '0;
    logic [2:0] access_size = '0;
    logic [31:0] write_data = '0;
    logic [6:0] pin_id = '0;
    logic pin_level = 1'b0;
    logic [7:0] dma_tx_byte = '0;
    logic dma_burst_last = 1'b0;
    logic [31:0] slave_rx = '0;
    logic select_ok = 1'b0;
    logic dma_rx_ready = 1'b0;
    logic done;
    logic [2:0] kind;
    logic [31:0] data;
    logic signed [4:0] cs_line;
    logic last;

    spi_controller_regs_rx_fifo_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy),
        .opcode(opcode), .reg_offset(reg_offset), .access_size(access_size),
        .write_data(write_data), .pin_id(pin_id), .pin_level(pin_level),
        .dma_tx_byte(dma_tx_byte), .dma_burst_last(dma_burst_last),
        .slave_rx(slave_rx), .select_ok(select_ok), .dma_rx_ready(dma_rx_ready),
        .done(done), .kind(kind), .data(data), .cs_line(cs_line), .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [31:0] cr1_q, cr2_q;
    logic [7:0]  fifo_mem [DEPTH];
    int          fifo_wp, fifo_rp, fifo_fill;
    int          lg_sel, ph_sel;
    bit          pin_held;
    int          line_map [3];

    spi_item_t pend_q [$];
    spi_res_t  want_q [$];
    spi_res_t  staged [$];
    spi_item_t cur;
    bit        no_idle = 1'b0;
    int        errors = 0;
    int        quiet_cycles = 0;

    function automatic logic [31:0] lane_mask(logic [2:0] size);
        if (size == 3'd1) return 32'hFF;
        if (size == 3'd2) return 32'hFFFF;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] lane_get(logic [31:0] r, logic [1:0] sub,
                                             logic [2:0] size);
        if (size >= 3'd4) return r;
        return (r >> (sub * 8)) & lane_mask(size);
    endfunction

    function automatic logic [31:0] lane_put(logic [31:0] old, logic [1:0] sub,
                                             logic [31:0] v, logic [2:0] size);
        logic [31:0] m;
        m = lane_mask(size);
        if (size >= 3'd4) return v;
        return (old & ~(m << (sub * 8))) | ((v & m) << (sub * 8));
    endfunction

    function automatic void emit(logic [2:0] k, logic [31:0] d, int cs);
        spi_res_t r;
        r.kind = k;
        r.data = d;
        r.cs = 5'(cs);
        r.last = 1'b0;
        staged.push_back(r);
    endfunction

    function automatic void tx_req_check();
        if (cr1_q[CR1_EN_BIT] && cr2_q[CR2_TXDMA_BIT] && ph_sel >= 0)
            emit(K_TXREQ, 32'd0, ph_sel);
    endfunction

    function automatic void drop_select();
        if (ph_sel >= 0)
            emit(K_RELEASE, 32'd0, ph_sel);
        lg_sel = -1;
        ph_sel = -1;
        pin_held = 1'b0;
    endfunction

    function automatic void swap_byte(logic [7:0] txb, logic [7:0] ans, logic rdy);
        logic [7:0] rx;
        rx = 8'hFF;
        if (ph_sel >= 0)
        begin
            emit(K_XCHG, {24'd0, txb}, ph_sel);
            rx = ans;
        end
        if (cr2_q[CR2_RXDMA_BIT] && rdy)
            emit(K_RXDMA, {24'd0, rx}, ph_sel);
        else if (fifo_fill < DEPTH)
        begin
            fifo_mem[fifo_wp] = rx;
            fifo_wp = (fifo_wp + 1) % DEPTH;
            fifo_fill++;
        end
    endfunction

    function automatic int pin_to_dev(logic [6:0] p);
        case (p)
            PIN_DEV4: return 4;
            PIN_DEV2: return 2;
            PIN_DEV3: return 3;
            PIN_DEV1: return 1;
            default:  return -1;
        endcase
    endfunction

    function automatic int dev_to_line(int dev);
        if (dev == 1) return line_map[CFG_DEV1];
        if (dev == 2) return line_map[CFG_DEV2];
        if (dev == 4) return line_map[CFG_DEV4];
        return -1;
    endfunction

    function automatic void predict_results(spi_item_t it);
        logic [1:0]  rsel, sub;
        logic [31:0] v, sr;
        int nbytes, dev, ph;
        rsel = it.off[3:2];
        sub = it.off[1:0];
        staged.delete();
        case (it.op)
            OP_READ:
            begin
                if (rsel == REG_CR1)
                    v = lane_get(cr1_q, sub, it.size);
                else if (rsel == REG_CR2)
                    v = lane_get(cr2_q, sub, it.size);
                else if (rsel == REG_SR)
                begin
                    sr = 32'h2 | (fifo_fill > 0 ? 32'h1 : 32'h0)
                        | (lg_sel >= 0 ? 32'h80 : 32'h0);
                    v = lane_get(sr, sub, it.size);
                end
                else
                begin
                    v = 32'hFF;
                    if (fifo_fill > 0)
                    begin
                        v = {24'd0, fifo_mem[fifo_rp]};
                        fifo_rp = (fifo_rp + 1) % DEPTH;
                        fifo_fill--;
                    end
                    v = lane_get(v, sub, it.size);
                end
                emit(K_READ, v, -1);
            end
            OP_WRITE:
            begin
                if (rsel == REG_CR1)
                begin
                    cr1_q = lane_put(cr1_q, sub, it.wdata, it.size);
                    if (!cr1_q[CR1_EN_BIT] && !pin_held)
                        drop_select();
                    else
                        tx_req_check();
                end
                else if (rsel == REG_CR2)
                begin
                    cr2_q = lane_put(cr2_q, sub, it.wdata, it.size);
                    tx_req_check();
                end
                else if (rsel == REG_DATA && cr1_q[CR1_EN_BIT])
                begin
                    nbytes = (it.size == 0) ? 1 : (it.size > 4 ? 4 : it.size);
                    for (int i = 0; i < nbytes; i++)
                        swap_byte(it.wdata[i*8 +: 8], it.answers[i*8 +: 8], it.rdy);
                end
            end
            OP_PIN:
            begin
                dev = pin_to_dev(it.pin);
                if (dev >= 0)
                begin
                    if (!it.lvl)
                    begin
                        ph = dev_to_line(dev);
                        if (ph >= 0)
                        begin
                            if (lg_sel == dev && ph_sel == ph)
                                pin_held = 1'b1;
                            else if (it.selok)
                            begin
                                emit(K_SELECT, 32'd0, ph);
                                lg_sel = dev;
                                ph_sel = ph;
                                pin_held = 1'b1;
                            end
                        end
                        tx_req_check();
                    end
                    else if (lg_sel == dev && pin_held)
                        drop_select();
                end
            end
            default:
            begin
                if (cr1_q[CR1_EN_BIT])
                    swap_byte(it.txb, it.answers[7:0], it.rdy);
            end
        endcase
        if (staged.size() > 0)
            staged[staged.size() - 1].last = 1'b1;
        foreach (staged[i])
            want_q.push_back(staged[i]);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                predict_results(cur);
            if (!start || !busy)
            begin
                if (pend_q.size() > 0 && (no_idle || $urandom_range(99) >= 23))
                begin
                    cur = pend_q.pop_front();
                    opcode <= cur.op;
                    reg_offset <= cur.off;
                    access_size <= cur.size;
                    write_data <= cur.wdata;
                    pin_id <= cur.pin;
                    pin_level <= cur.lvl;
                    dma_tx_byte <= cur.txb;
                    dma_burst_last <= cur.blast;
                    slave_rx <= cur.answers;
                    select_ok <= cur.selok;
                    dma_rx_ready <= cur.rdy;
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (want_q.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("unexpected result kind=%0d data=%h cs=%0d last=%b",
                             kind, data, cs_line, last);
            end
            else
            begin
                spi_res_t w;
                w = want_q.pop_front();
                if (w.kind !== kind || w.data !== data || w.cs !== cs_line
                    || w.last !== last)
                begin
                    errors++;
                    if (errors <= SHOW_MAX)
                        $display({"mismatch: want kind=%0d data=%h cs=%0d last=%b,",
                                  " got kind=%0d data=%h cs=%0d last=%b"},
                                 w.kind, w.data, w.cs, w.last,
                                 kind, data, cs_line, last);
                end
            end
        end
    end

    // watchdog: cycles with no item and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic spi_item_t mk(logic [1:0] op, logic [3:0] off, logic [2:0] size,
                                     logic [31:0] wd, logic [6:0] pin, logic lvl,
                                     logic [7:0] txb, logic selok, logic rdy);
        spi_item_t it;
        it.op = op;
        it.off = off;
        it.size = size;
        it.wdata = wd;
        it.pin = pin;
        it.lvl = lvl;
        it.txb = txb;
        it.blast = 1'($urandom);
        it.answers = $urandom;
        it.selok = selok;
        it.rdy = rdy;
        return it;
    endfunction

    function automatic spi_item_t rand_item(bit fill_heavy);
        spi_item_t it;
        int pick;
        logic [6:0] known [4];
        known = '{PIN_DEV1, PIN_DEV2, PIN_DEV3, PIN_DEV4};
        it = mk(2'($urandom), 4'($urandom), 3'($urandom_range(4)), $urandom,
                7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom_range(3) != 0),
                1'($urandom));
        pick = $urandom_range(99);
        if (fill_heavy)
        begin
            // mostly data writes with DMA not ready, to fill and overflow the FIFO
            it.op = (pick < 80) ? OP_WRITE : OP_READ;
            if (pick < 80)
                it.off = {REG_DATA, 2'($urandom)};
            it.rdy = ($urandom_range(9) == 0);
        end
        else if (pick < 20)
            it.op = OP_READ;
        else if (pick < 55)
        begin
            it.op = OP_WRITE;
            if ($urandom_range(1) == 0)
                it.off = {REG_DATA, 2'($urandom)};
            else if (it.off[3:2] == REG_CR1 && $urandom_range(3) != 0)
                it.wdata[6] = 1'b1;
        end
        else if (pick < 80)
            it.op = OP_PIN;
        else
            it.op = OP_DMA;
        if ($urandom_range(4) != 0)
            it.pin = known[$urandom_range(3)];
        return it;
    endfunction

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pend_q.size() != 0 || start || want_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_lines(int a, int b, int c);
        int vals [3];
        vals = '{a, b, c};
        for (int i = 0; i < 3; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= 2'(i);
            cfg_wdata <= 5'(vals[i]);
            line_map[i] = vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int phase_lines [4][3];
        phase_lines = '{'{3, 15, 0}, '{-1, -1, -1}, '{15, 0, 7}, '{8, -1, 12}};
        cr1_q = '0;
        cr2_q = '0;
        fifo_wp = 0;
        fifo_rp = 0;
        fifo_fill = 0;
        lg_sel = -1;
        ph_sel = -1;
        pin_held = 1'b0;
        line_map = '{-1, -1, -1};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE) @(posedge clk);

        set_lines(phase_lines[0][0], phase_lines[0][1], phase_lines[0][2]);
        pend_q.push_back(mk(OP_READ, 4'd8, 3'd4, 0, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_READ, 4'd13, 3'd1, 0, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_WRITE, 4'd0, 3'd1, 32'h40, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_WRITE, 4'd12, 3'd0, 32'hA5, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_WRITE, 4'd4, 3'd2, 32'h0003, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_PIN, 4'd0, 3'd0, 0, PIN_DEV1, 1'b0, 0, 1'b0, 0));
        pend_q.push_back(mk(OP_PIN, 4'd0, 3'd0, 0, PIN_DEV1, 1'b0, 0, 1'b1, 0));
        pend_q.push_back(mk(OP_PIN, 4'd0, 3'd0, 0, PIN_DEV1, 1'b0, 0, 1'b0, 0));
        pend_q.push_back(mk(OP_PIN, 4'd0, 3'd0, 0, PIN_DEV4, 1'b0, 0, 1'b1, 0));
        pend_q.push_back(mk(OP_DMA, 4'd0, 3'd0, 0, 0, 0, 8'hFF, 1, 1'b1));
        pend_q.push_back(mk(OP_WRITE, 4'd12, 3'd7, 32'hFFFF_FFFF, 0, 0, 0, 1, 1'b0));
        pend_q.push_back(mk(OP_PIN, 4'd0, 3'd0, 0, PIN_DEV3, 1'b0, 0, 1, 0));
        pend_q.push_back(mk(OP_PIN, 4'd0, 3'd0, 0, 7'd127, 1'b0, 0, 1, 0));
        pend_q.push_back(mk(OP_READ, 4'd9, 3'd3, 0, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_WRITE, 4'd8, 3'd4, 32'hFFFF_FFFF, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_READ, 4'd12, 3'd4, 0, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_READ, 4'd15, 3'd2, 0, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_PIN, 4'd0, 3'd0, 0, PIN_DEV4, 1'b1, 0, 1, 0));
        pend_q.push_back(mk(OP_WRITE, 4'd0, 3'd4, 32'h0, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_DMA, 4'd0, 3'd0, 0, 0, 0, 8'h00, 1, 1'b1));
        pend_q.push_back(mk(OP_WRITE, 4'd15, 3'd2, 32'h1234, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_READ, 4'd6, 3'd2, 0, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_WRITE, 4'd1, 3'd3, 32'hFFFF_FFFF, 0, 0, 0, 1, 0));
        pend_q.push_back(mk(OP_READ, 4'd0, 3'd0, 0, 0, 0, 0, 1, 0));
        wait_quiet();

        for (int ph = 0; ph < 4; ph++)
        begin
            set_lines(phase_lines[ph][0], phase_lines[ph][1], phase_lines[ph][2]);
            no_idle = (ph == 2);
            // enable controller so data traffic gets going
            pend_q.push_back(mk(OP_WRITE, 4'd0, 3'd4, 32'h40, 0, 0, 0, 1, 0));
            for (int i = 0; i < 30; i++)
                pend_q.push_back(rand_item(ph == 1 && i < 25));
            wait_quiet();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
